[design/mrc_pkg.sv]
package mrc_pkg;

	// frame limit and count width
	localparam int MAX_FRAME = 256;
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int NUM_WORDS = 5;

	// crc-16/modbus
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// function codes
	localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
	localparam logic [7:0] FC_READ_INPUT    = 8'h04;
	localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;

	// function classes
	localparam logic [2:0] FCLS_OTHER        = 3'd0;
	localparam logic [2:0] FCLS_READ_HOLDING = 3'd1;
	localparam logic [2:0] FCLS_READ_INPUT   = 3'd2;
	localparam logic [2:0] FCLS_WRITE_SINGLE = 3'd3;
	localparam logic [2:0] FCLS_WRITE_MULTI  = 3'd4;

	localparam logic [7:0] SLAVE_ADDR_RESET = 8'd53;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        crc_ok;
		logic        address_ok;
		logic        too_short;
		logic [2:0]  function_class;
		logic [7:0]  function_code;
		logic [15:0] word_zero;
		logic [15:0] word_one;
		logic [15:0] word_two;
		logic [15:0] word_three;
		logic [15:0] word_four;
	} out_item_t;

	// one byte through the reflected crc, bit by bit
	function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [2:0] classify(input logic [7:0] code);
		logic [2:0] cls;
		case (code)
			FC_READ_HOLDING: cls = FCLS_READ_HOLDING;
			FC_READ_INPUT:   cls = FCLS_READ_INPUT;
			FC_WRITE_SINGLE: cls = FCLS_WRITE_SINGLE;
			FC_WRITE_MULTI:  cls = FCLS_WRITE_MULTI;
			default:         cls = FCLS_OTHER;
		endcase
		return cls;
	endfunction

endpackage

[design/mrc_frame_track.sv]
module mrc_frame_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  mrc_pkg::in_item_t item,
	input  logic [7:0]        slave_address,
	output mrc_pkg::out_item_t result
);
	import mrc_pkg::*;

	logic [15:0]      crc_q;
	logic [7:0]       held0_q;
	logic [7:0]       held1_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       address_q;
	logic [7:0]       code_q;
	logic [15:0]      words_q [NUM_WORDS];

	logic [15:0]      crc_next;
	logic [15:0]      words_next [NUM_WORDS];
	logic [CNT_W-1:0] count_next;
	logic             in_window;
	logic [3:0]       offset;
	logic             below_max;

	assign below_max = byte_count_q < CNT_W'(MAX_FRAME);
	assign in_window = below_max && (byte_count_q >= CNT_W'(3)) && (byte_count_q <= CNT_W'(12));
	assign offset    = byte_count_q[3:0] - 4'd3;

	// the byte leaving the delay line enters the crc
	assign crc_next   = (byte_count_q >= CNT_W'(2)) ? crc_absorb(crc_q, held0_q) : crc_q;
	assign count_next = below_max ? byte_count_q + CNT_W'(1) : byte_count_q;

	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			words_next[w] = words_q[w];
			if (in_window && (offset[3:1] == 3'(w))) begin
				if (offset[0]) begin
					words_next[w][7:0] = item.data_byte;
				end else begin
					words_next[w][15:8] = item.data_byte;
				end
			end
		end
	end

	always_comb begin
		result = '0;
		if (byte_count_q < CNT_W'(2)) begin
			result.too_short = 1'b1;
		end else begin
			result.crc_ok         = crc_next == {held1_q, item.data_byte};
			result.address_ok     = address_q == slave_address;
			result.function_class = classify(code_q);
			result.function_code  = code_q;
			result.word_zero      = words_next[0];
			result.word_one       = words_next[1];
			result.word_two       = words_next[2];
			result.word_three     = words_next[3];
			result.word_four      = words_next[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_SEED;
			held0_q      <= '0;
			held1_q      <= '0;
			byte_count_q <= '0;
			address_q    <= '0;
			code_q       <= '0;
			for (int w = 0; w < NUM_WORDS; w++) begin
				words_q[w] <= '0;
			end
		end else if (advance) begin
			if (item.last_byte) begin
				// frame done, back to a clean slate
				crc_q        <= CRC_SEED;
				held0_q      <= '0;
				held1_q      <= '0;
				byte_count_q <= '0;
				address_q    <= '0;
				code_q       <= '0;
				for (int w = 0; w < NUM_WORDS; w++) begin
					words_q[w] <= '0;
				end
			end else begin
				crc_q        <= crc_next;
				held0_q      <= held1_q;
				held1_q      <= item.data_byte;
				byte_count_q <= count_next;
				if (byte_count_q == CNT_W'(0)) begin
					address_q <= item.data_byte;
				end
				if (byte_count_q == CNT_W'(1)) begin
					code_q <= item.data_byte;
				end
				for (int w = 0; w < NUM_WORDS; w++) begin
					words_q[w] <= words_next[w];
				end
			end
		end
	end

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.last_byte |=> byte_count_q == '0 && crc_q == CRC_SEED)
		else $error("frame state not cleared after final byte");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_W'(MAX_FRAME))
		else $error("byte count beyond frame limit");

	a_short_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result.too_short |-> !result.crc_ok && !result.address_ok
			&& result.function_class == FCLS_OTHER)
		else $error("short frame with other flags set");

endmodule

[design/modbus_rtu_response_checker_unit.sv]
// modbus rtu response checker: one byte per transfer, one result per frame
// a result is offered from the result register, which loads when its final byte moves on from the input register
// throughput: one byte per cycle while no final byte is blocked; the byte-wide crc update is combinational xor logic
// a held result only blocks bytes once a further final byte reaches the input register
// reset (arst_n low, asynchronous): frame state cleared, crc seed 0xffff, address 53
module modbus_rtu_response_checker_unit (
	input  logic               clk,
	input  logic               arst_n,
	// byte channel
	input  logic               byte_valid,
	output logic               byte_stall,
	input  mrc_pkg::in_item_t  byte_item,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output mrc_pkg::out_item_t result_item,
	// slave address register write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import mrc_pkg::*;

	// input register
	logic      valid_s1;
	in_item_t  item_s1;

	// result register
	logic      result_valid_q;
	out_item_t result_q;

	logic [7:0] slave_address_q;
	logic       advance;
	out_item_t  result_next;

	// the user must write the register only while the block is idle; unchecked, so always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= SLAVE_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			slave_address_q <= cfg_data;
		end
	end

	// a byte in the input register moves on unless it closes a frame and the
	// result register still holds a result that is not being taken
	assign advance    = valid_s1 && (!item_s1.last_byte || !result_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	// crc, delay line, header capture and register words
	mrc_frame_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item          (item_s1),
		.slave_address (slave_address_q),
		.result        (result_next)
	);

	// result register: loads on the final byte of a frame, empties when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && item_s1.last_byte && result_valid_q)
		else $error("byte stall without a blocked final byte");

	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last_byte |=> result_valid_q)
		else $error("final byte produced no result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q && !(advance && item_s1.last_byte) |=> !result_valid_q)
		else $error("result appeared without a final byte");

endmodule
